// ----- rtl/grid_bilinear_interpolator_assert.svh -----
// ---------------------------------------------------------------------------
// grid_bilinear_interpolator assertion macros
// shared property forms for the port level checks
// ---------------------------------------------------------------------------
`ifndef GRID_BILINEAR_INTERPOLATOR_ASSERT_SVH
`define GRID_BILINEAR_INTERPOLATOR_ASSERT_SVH

// implication checked every clock outside reset
`define GBI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbi implication check failed");

// invariant checked every clock outside reset
`define GBI_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("gbi invariant check failed");

`endif

// ----- rtl/gbi_pkg.sv -----
// ---------------------------------------------------------------------------
// gbi_pkg
// types and codes shared by the grid bilinear interpolator files
// ---------------------------------------------------------------------------
package gbi_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    localparam logic [1:0] ST_LOAD    = 2'd0;
    localparam logic [1:0] ST_INTERP  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_X_TO_GRID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_TO_GRID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 3'd4;

    localparam logic [31:0]        RST_X_TO_GRID   = 32'd65536;
    localparam logic [31:0]        RST_Y_TO_GRID   = 32'd65536;
    localparam logic signed [31:0] RST_DATA_SCALE  = 32'sd65536;
    localparam logic [9:0]         RST_COLS_IN_USE = 10'd512;
    localparam logic [10:0]        RST_ROWS_IN_USE = 11'd1024;

    localparam int NUM_BANKS = 4;

    typedef struct packed {
        logic               operation;
        logic [8:0]         load_col;
        logic [9:0]         load_row;
        logic signed [31:0] load_value;
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
    } t_gbi_req;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_gbi_res;

    typedef struct packed {
        logic [31:0]        x_to_grid;
        logic [31:0]        y_to_grid;
        logic signed [31:0] data_scale;
        logic [9:0]         cols_in_use;
        logic [10:0]        rows_in_use;
    } t_gbi_cfg;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [15:0] wx;
        logic [15:0] wy;
        logic        i_odd;
        logic        j_odd;
    } t_gbi_meta;

endpackage

// ----- rtl/gbi_bank_ram.sv -----
// ---------------------------------------------------------------------------
// gbi_bank_ram
// single port sample bank with registered read data
// ---------------------------------------------------------------------------
module gbi_bank_ram #(
    parameter int DEPTH = 131072,
    parameter int AW    = 17
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gbi_front.sv -----
// ---------------------------------------------------------------------------
// gbi_front
// position scaling, cell bounds check and bank addressing
// ---------------------------------------------------------------------------
module gbi_front #(
    parameter int GRID_COLS = 512,
    parameter int GRID_ROWS = 1024,
    parameter int BANK_AW   = 17
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_fire,
    input  gbi_pkg::t_gbi_req                              i_req,
    input  gbi_pkg::t_gbi_cfg                              i_cfg,
    output logic [gbi_pkg::NUM_BANKS-1:0]                  o_we,
    output logic [gbi_pkg::NUM_BANKS-1:0]                  o_re,
    output logic [gbi_pkg::NUM_BANKS-1:0][BANK_AW-1:0]     o_addr,
    output logic [31:0]                                    o_wdata,
    output gbi_pkg::t_gbi_meta                             o_meta
);

    import gbi_pkg::*;

    localparam int HALF_COLS = (GRID_COLS + 1) / 2;
    localparam int HALF_ROWS = (GRID_ROWS + 1) / 2;
    localparam int CHW       = (HALF_COLS > 1) ? $clog2(HALF_COLS) : 1;
    localparam int RHW       = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;

    logic        r_valid;
    logic        r_op;
    logic [8:0]  r_col;
    logic [9:0]  r_row;
    logic [31:0] r_load_value;
    logic [63:0] r_gx;
    logic [63:0] r_gy;
    t_gbi_meta   r_meta;
    t_gbi_meta   n_meta;

    logic [31:0]        cell_i;
    logic [31:0]        cell_j;
    logic [32:0]        lim_cols;
    logic [32:0]        lim_rows;
    logic               outside;
    logic [CHW-1:0]     ch_even;
    logic [CHW-1:0]     ch_odd;
    logic [RHW-1:0]     rh_even;
    logic [RHW-1:0]     rh_odd;
    logic [NUM_BANKS-1:0][BANK_AW-1:0] raddr;
    logic [BANK_AW-1:0] waddr;
    logic [1:0]         wbank;
    logic               in_range;
    logic               load_we;
    logic               rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_fire;
        end
    end

    // scale into grid units, q32.32
    always_ff @(posedge i_clk) begin
        r_op         <= i_req.operation;
        r_col        <= i_req.load_col;
        r_row        <= i_req.load_row;
        r_load_value <= i_req.load_value;
        r_gx         <= 64'(i_req.pos_x) * 64'(i_cfg.x_to_grid);
        r_gy         <= 64'(i_req.pos_y) * 64'(i_cfg.y_to_grid);
    end

    always_comb begin
        cell_i   = r_gx[63:32];
        cell_j   = r_gy[63:32];
        lim_cols = (33'(i_cfg.cols_in_use) < 33'(GRID_COLS)) ?
                   33'(i_cfg.cols_in_use) : 33'(GRID_COLS);
        lim_rows = (33'(i_cfg.rows_in_use) < 33'(GRID_ROWS)) ?
                   33'(i_cfg.rows_in_use) : 33'(GRID_ROWS);
        outside  = ((33'(cell_i) + 33'd1) >= lim_cols) ||
                   ((33'(cell_j) + 33'd1) >= lim_rows);

        // each corner parity lives in its own bank
        ch_odd  = CHW'(cell_i >> 1);
        ch_even = CHW'(cell_i >> 1) + CHW'(cell_i[0]);
        rh_odd  = RHW'(cell_j >> 1);
        rh_even = RHW'(cell_j >> 1) + RHW'(cell_j[0]);
        for (int k = 0; k < NUM_BANKS; k++) begin
            raddr[k] = BANK_AW'(k[1] ? rh_odd : rh_even) * BANK_AW'(HALF_COLS)
                     + BANK_AW'(k[0] ? ch_odd : ch_even);
        end

        wbank    = {r_row[0], r_col[0]};
        waddr    = BANK_AW'(RHW'(r_row >> 1)) * BANK_AW'(HALF_COLS)
                 + BANK_AW'(CHW'(r_col >> 1));
        in_range = (32'(r_col) < 32'(GRID_COLS)) && (32'(r_row) < 32'(GRID_ROWS));
        load_we  = r_valid && (r_op == OP_LOAD) && in_range;
        rd       = r_valid && (r_op == OP_INTERP) && !outside;

        for (int k = 0; k < NUM_BANKS; k++) begin
            o_we[k]   = load_we && (wbank == 2'(k));
            o_re[k]   = rd;
            o_addr[k] = (r_op == OP_LOAD) ? waddr : raddr[k];
        end
        o_wdata = r_load_value;

        n_meta.valid = r_valid;
        if (r_op == OP_LOAD) begin
            n_meta.status = ST_LOAD;
        end else if (outside) begin
            n_meta.status = ST_OUTSIDE;
        end else begin
            n_meta.status = ST_INTERP;
        end
        n_meta.wx    = r_gx[31:16];
        n_meta.wy    = r_gy[31:16];
        n_meta.i_odd = cell_i[0];
        n_meta.j_odd = cell_j[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end else begin
            r_meta <= n_meta;
        end
    end

    assign o_meta = r_meta;

endmodule

// ----- rtl/gbi_blend.sv -----
// ---------------------------------------------------------------------------
// gbi_blend
// pipelined bilinear blend, output scaling and saturation
// ---------------------------------------------------------------------------
module gbi_blend (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gbi_pkg::t_gbi_meta                    i_meta,
    input  logic [gbi_pkg::NUM_BANKS-1:0][31:0]   i_rdata,
    input  logic signed [31:0]                    i_data_scale,
    output logic                                  o_strobe,
    output gbi_pkg::t_gbi_res                     o_res
);

    import gbi_pkg::*;

    localparam int PIPE_STAGES = 6;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [1:0]             r_sts [PIPE_STAGES];

    logic [1:0]         b00;
    logic [1:0]         b10;
    logic [1:0]         b01;
    logic [1:0]         b11;
    logic signed [31:0] a00;
    logic signed [31:0] a10;
    logic signed [31:0] a01;
    logic signed [31:0] a11;
    logic [16:0]        wx_c;
    logic [16:0]        wy_c;
    logic signed [63:0] sum_rnd;
    logic signed [63:0] sc_rnd;
    logic               fits;
    logic signed [31:0] n_value;

    logic signed [48:0] r_p00;
    logic signed [48:0] r_p10;
    logic signed [48:0] r_p01;
    logic signed [48:0] r_p11;
    logic [15:0]        r_d_wy;
    logic signed [48:0] r_top;
    logic signed [48:0] r_bot;
    logic [15:0]        r_e_wy;
    logic signed [63:0] r_st;
    logic signed [63:0] r_sb;
    logic signed [31:0] r_interp;
    logic signed [63:0] r_sp;
    logic signed [31:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], i_meta.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sts[0] <= i_meta.status;
        for (int s = 1; s < PIPE_STAGES; s++) begin
            r_sts[s] <= r_sts[s-1];
        end
    end

    always_comb begin
        b00  = {i_meta.j_odd, i_meta.i_odd};
        b10  = {i_meta.j_odd, ~i_meta.i_odd};
        b01  = {~i_meta.j_odd, i_meta.i_odd};
        b11  = {~i_meta.j_odd, ~i_meta.i_odd};
        a00  = signed'(i_rdata[b00]);
        a10  = signed'(i_rdata[b10]);
        a01  = signed'(i_rdata[b01]);
        a11  = signed'(i_rdata[b11]);
        wx_c = 17'd65536 - 17'(i_meta.wx);
        wy_c = 17'd65536 - 17'(r_e_wy);

        sum_rnd = r_st + r_sb + 64'sh0000_0000_8000_0000;
        sc_rnd  = r_sp + 64'sh0000_0000_0000_8000;
        fits    = (sc_rnd[63:47] == {17{sc_rnd[63]}});
        if (r_sts[PIPE_STAGES-2] != ST_INTERP) begin
            n_value = 32'sd0;
        end else if (fits) begin
            n_value = signed'(sc_rnd[47:16]);
        end else if (sc_rnd[63]) begin
            n_value = 32'sh8000_0000;
        end else begin
            n_value = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        // horizontal weights
        r_p00  <= 49'(a00) * signed'(49'(wx_c));
        r_p10  <= 49'(a10) * signed'(49'(i_meta.wx));
        r_p01  <= 49'(a01) * signed'(49'(wx_c));
        r_p11  <= 49'(a11) * signed'(49'(i_meta.wx));
        r_d_wy <= i_meta.wy;
        r_top  <= r_p00 + r_p10;
        r_bot  <= r_p01 + r_p11;
        r_e_wy <= r_d_wy;
        // vertical weights, rounding, data scaling and saturation
        r_st     <= 64'(r_top) * signed'(64'(wy_c));
        r_sb     <= 64'(r_bot) * signed'(64'(r_e_wy));
        r_interp <= signed'(sum_rnd[63:32]);
        r_sp     <= 64'(r_interp) * 64'(i_data_scale);
        r_value  <= n_value;
    end

    assign o_strobe     = r_vld[PIPE_STAGES-1];
    assign o_res.value  = r_value;
    assign o_res.status = r_sts[PIPE_STAGES-1];

endmodule

// ----- rtl/grid_bilinear_interpolator.sv -----
// ---------------------------------------------------------------------------
// grid_bilinear_interpolator
// gridded field store with pipelined bilinear point queries
// ---------------------------------------------------------------------------
// requests enter on start with i_req; busy is low except during reset, so a
// request is taken every cycle. a load request writes one sample, an
// interpolate request blends the four corners of the cell under pos_x,pos_y.
// every request gives one result on o_res with o_strobe high for one cycle,
// in request order; the receiver cannot stall, nothing is held back.
// one request per cycle is sustained through the front, banks and blend.
// the sample store is four single port banks split by row and column
// parity, so all four corners are read in the same cycle; loads write and
// queries read in the same stage, so a query sees every earlier load.
// configuration is written on i_cfg_we/i_cfg_idx/i_cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// reset clears the pipeline and restores the configuration defaults; the
// store is not cleared and samples are undefined until loaded.
// ---------------------------------------------------------------------------
module grid_bilinear_interpolator #(
    parameter int GRID_COLS = 512,
    parameter int GRID_ROWS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  gbi_pkg::t_gbi_req                 i_req,
    input  logic                              i_cfg_we,
    input  logic [gbi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gbi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_strobe,
    output gbi_pkg::t_gbi_res                 o_res
);

    import gbi_pkg::*;

    localparam int HALF_COLS  = (GRID_COLS + 1) / 2;
    localparam int HALF_ROWS  = (GRID_ROWS + 1) / 2;
    localparam int BANK_DEPTH = HALF_COLS * HALF_ROWS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    t_gbi_cfg r_cfg;
    logic     fire;

    logic [NUM_BANKS-1:0]              bank_we;
    logic [NUM_BANKS-1:0]              bank_re;
    logic [NUM_BANKS-1:0][BANK_AW-1:0] bank_addr;
    logic [NUM_BANKS-1:0][31:0]        bank_rdata;
    logic [31:0]                       bank_wdata;
    t_gbi_meta                         meta;

    assign busy = !i_rst_n;
    assign fire = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_to_grid   <= RST_X_TO_GRID;
            r_cfg.y_to_grid   <= RST_Y_TO_GRID;
            r_cfg.data_scale  <= RST_DATA_SCALE;
            r_cfg.cols_in_use <= RST_COLS_IN_USE;
            r_cfg.rows_in_use <= RST_ROWS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_TO_GRID: begin
                    r_cfg.x_to_grid <= i_cfg_data;
                end
                CFG_Y_TO_GRID: begin
                    r_cfg.y_to_grid <= i_cfg_data;
                end
                CFG_DATA_SCALE: begin
                    r_cfg.data_scale <= signed'(i_cfg_data);
                end
                CFG_COLS_IN_USE: begin
                    r_cfg.cols_in_use <= i_cfg_data[9:0];
                end
                CFG_ROWS_IN_USE: begin
                    r_cfg.rows_in_use <= i_cfg_data[10:0];
                end
                default: begin
                end
            endcase
        end
    end

    gbi_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .BANK_AW   (BANK_AW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .o_we    (bank_we),
        .o_re    (bank_re),
        .o_addr  (bank_addr),
        .o_wdata (bank_wdata),
        .o_meta  (meta)
    );

    for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
        gbi_bank_ram #(
            .DEPTH (BANK_DEPTH),
            .AW    (BANK_AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[k]),
            .i_re    (bank_re[k]),
            .i_addr  (bank_addr[k]),
            .i_wdata (bank_wdata),
            .o_rdata (bank_rdata[k])
        );
    end

    gbi_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_meta       (meta),
        .i_rdata      (bank_rdata),
        .i_data_scale (r_cfg.data_scale),
        .o_strobe     (o_strobe),
        .o_res        (o_res)
    );

endmodule

// ----- rtl/gbi_checker.sv -----
// ---------------------------------------------------------------------------
// gbi_checker
// port level checks on request to result ordering, status and value, bound to the top level
// ---------------------------------------------------------------------------
`include "grid_bilinear_interpolator_assert.svh"

module gbi_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input gbi_pkg::t_gbi_req i_req,
    input logic              o_strobe,
    input gbi_pkg::t_gbi_res o_res
);

    import gbi_pkg::*;

    // every result traces back to a request taken by the block
    `GBI_ASSERT_IMPL(a_result_has_request, i_clk, i_rst_n, o_strobe, $past(start && !busy, 8))

    // a load request answers with the load status
    `GBI_ASSERT_IMPL(a_load_answers_done, i_clk, i_rst_n, o_strobe && $past(start && !busy && i_req.operation == OP_LOAD, 8), o_res.status == ST_LOAD)

    // only interpolated results carry a nonzero value
    `GBI_ASSERT_ALWAYS(a_flagged_value_zero, i_clk, i_rst_n, !o_strobe || o_res.status == ST_INTERP || o_res.value == 32'sd0)

endmodule

bind grid_bilinear_interpolator gbi_checker u_gbi_checker (.*);
